/* design/moc_pkg.sv */
package moc_pkg;

  // default widest unpadded source row; the line store holds two entries more
  localparam int unsigned DEF_MAX_WIDTH = 1024;

  // fixed field widths
  localparam int unsigned SRC_W_W    = 11;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned CFG_DATA_W = 12;

  // largest source height that is honored
  localparam logic [ROW_W-1:0] HEIGHT_LIMIT = 12'd4094;

  // finished-pixel queue between line stage and output register
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCW         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QAW         = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_e;

  // one finished pixel position, column travels beside it
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             contour;
    logic             center;
    logic             last_row;
    logic             last_col;
  } rec_t;

  typedef struct packed {
    logic s1_valid;
    logic push;
  } line_status_t;

  typedef struct packed {
    logic [QCW-1:0] count;
  } emit_status_t;

endpackage

/* design/moc_ram.sv */
module moc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1026,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/moc_line.sv */
module moc_line #(
  parameter int unsigned MAX_WIDTH = moc_pkg::DEF_MAX_WIDTH,
  localparam int unsigned ColW = $clog2(MAX_WIDTH + 2)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [moc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              pixel_visible_i,
  output logic                              in_stall_o,
  input  moc_pkg::emit_status_t             emit_status_i,
  output moc_pkg::line_status_t             status_o,
  output logic [ColW-1:0]                   push_col_o,
  output moc_pkg::rec_t                     push_rec_o
);

  import moc_pkg::*;

  logic [SRC_W_W-1:0] src_w_q;
  logic [ROW_W-1:0]   src_h_q;
  logic [ColW-1:0]    col_q;
  logic [ROW_W-1:0]   row_q;
  logic               left_q;

  logic [ColW-1:0]    eff_w, last_col, c_eff, raddr;
  logic [ROW_W-1:0]   eff_h, last_row, r_eff;
  logic               accept;
  logic               a_first, a_last_row, a_last_col;
  logic [QCW:0]       load;

  // stage 1: store read data is valid here
  logic               s1_valid_q;
  logic [ColW-1:0]    s1_col_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic               s1_cur_q, s1_first_q, s1_up_ok_q, s1_last_row_q, s1_last_col_q;

  // store entry of the stage-1 pixel, read one pixel early as the right neighbor
  logic [1:0]         ahead_q;

  logic [1:0]         rdata, wdata, old;
  logic               push, center, up, right;

  always_comb begin
    if (src_w_q == '0) begin
      eff_w = ColW'(1);
    end else if (32'(src_w_q) > MAX_WIDTH) begin
      eff_w = ColW'(MAX_WIDTH);
    end else begin
      eff_w = ColW'(src_w_q);
    end
    if (src_h_q == '0) begin
      eff_h = ROW_W'(1);
    end else if (src_h_q > HEIGHT_LIMIT) begin
      eff_h = HEIGHT_LIMIT;
    end else begin
      eff_h = src_h_q;
    end
  end

  assign last_col = eff_w + ColW'(1);
  assign last_row = eff_h + ROW_W'(1);
  assign c_eff    = (col_q > last_col) ? last_col : col_q;
  assign r_eff    = (row_q > last_row) ? last_row : row_q;

  assign a_first    = (r_eff == '0);
  assign a_last_row = (r_eff >= last_row);
  assign a_last_col = (c_eff >= last_col);

  // every item in flight holds a queue slot in reserve
  assign load = (QCW+1)'(emit_status_i.count) + (QCW+1)'(s1_valid_q);
  assign in_stall_o = (load >= (QCW+1)'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_W_W'(1);
      src_h_q <= ROW_W'(1);
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SOURCE_WIDTH:  src_w_q <= cfg_data_i[SRC_W_W-1:0];
        REG_SOURCE_HEIGHT: src_h_q <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (a_last_col) begin
        col_q <= '0;
        row_q <= a_last_row ? '0 : r_eff + ROW_W'(1);
      end else begin
        col_q <= c_eff + ColW'(1);
        row_q <= r_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q      <= c_eff;
      s1_row_q      <= r_eff;
      // border positions are forced invisible
      s1_cur_q      <= pixel_visible_i && !a_first && !a_last_row && (c_eff != '0) && !a_last_col;
      s1_first_q    <= a_first;
      s1_up_ok_q    <= (r_eff >= ROW_W'(2));
      s1_last_row_q <= a_last_row;
      s1_last_col_q <= a_last_col;
    end
  end

  // read the entry right of the pixel, nothing past the last column
  assign raddr = a_last_col ? '0 : c_eff + ColW'(1);

  moc_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH + 2)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      ahead_q <= rdata;
    end
  end

  // column zero is border: its entry only ever holds zero
  assign old    = (s1_col_q == '0) ? 2'b00 : ahead_q;
  // bit 0 previous row, bit 1 the row before
  assign wdata  = s1_first_q ? 2'b00 : {old[0], s1_cur_q};
  assign push   = s1_valid_q && !s1_first_q;
  assign center = old[0];
  assign up     = s1_up_ok_q && old[1];
  assign right  = !s1_last_col_q && rdata[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 1'b0;
    end else if (cfg_we_i) begin
      left_q <= 1'b0;
    end else if (s1_valid_q) begin
      left_q <= (s1_first_q || s1_last_col_q) ? 1'b0 : old[0];
    end
  end

  assign push_col_o          = s1_col_q;
  assign push_rec_o.row      = s1_row_q;
  assign push_rec_o.contour  = !center && (s1_cur_q || up || left_q || right);
  assign push_rec_o.center   = center;
  assign push_rec_o.last_row = s1_last_row_q;
  assign push_rec_o.last_col = s1_last_col_q;

  assign status_o.s1_valid = s1_valid_q;
  assign status_o.push     = push;

endmodule

/* design/moc_emit.sv */
module moc_emit #(
  parameter int unsigned MAX_WIDTH = moc_pkg::DEF_MAX_WIDTH,
  localparam int unsigned ColW = $clog2(MAX_WIDTH + 2)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  moc_pkg::line_status_t        line_status_i,
  input  logic [ColW-1:0]              push_col_i,
  input  moc_pkg::rec_t                push_rec_i,
  output moc_pkg::emit_status_t        status_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         contour_o,
  output logic [ColW-1:0]              out_column_o,
  output logic [moc_pkg::ROW_W-1:0]    out_row_o,
  output logic                         frame_last_o
);

  import moc_pkg::*;

  logic [ColW-1:0] q_col [QUEUE_DEPTH];
  rec_t            q_rec [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]  count_q;
  logic            second_q;

  logic            out_valid_q, contour_q, last_q;
  logic [ColW-1:0] col_q;
  logic [ROW_W-1:0] row_q;

  logic            head_valid, load, pop;
  logic [ColW-1:0] head_col;
  rec_t            head_rec;

  assign head_valid = (count_q != '0);
  assign head_col   = q_col[rd_ptr_q];
  assign head_rec   = q_rec[rd_ptr_q];
  assign load       = head_valid && (!out_valid_q || !out_stall_i);
  // last padded row gives a second result for its own position
  assign pop        = load && (second_q || !head_rec.last_row);

  always_ff @(posedge clk_i) begin
    if (line_status_i.push) begin
      q_col[wr_ptr_q] <= push_col_i;
      q_rec[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (line_status_i.push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
      count_q <= count_q + QCW'(line_status_i.push) - QCW'(pop);
      if (load) begin
        second_q <= !pop;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q <= head_col;
      if (second_q) begin
        contour_q <= head_rec.center;
        row_q     <= head_rec.row;
        last_q    <= head_rec.last_col;
      end else begin
        contour_q <= head_rec.contour;
        row_q     <= head_rec.row - ROW_W'(1);
        last_q    <= 1'b0;
      end
    end
  end

  assign status_o.count = count_q;
  assign out_valid_o    = out_valid_q;
  assign contour_o      = contour_q;
  assign out_column_o   = col_q;
  assign out_row_o      = row_q;
  assign frame_last_o   = last_q;

endmodule

/* design/mask_outer_contour.sv */
// channel   direction  handshake                 payload
// config    in         cfg_we_i                  cfg_index_i, cfg_data_i
// pixel     in         in_valid_i / in_stall_o   pixel_visible_i
// result    out        out_valid_o / out_stall_i contour_o, out_column_o, out_row_o, frame_last_o
//
// one pixel request per cycle while in_stall_o is low; inputs of the last padded row give two results each
//   and hold their queue entry until the single-result output register has taken both
// the first result of a request passes stage 1 and the queue into the output register after the request is accepted
// the line store is one 2-bit-wide ram read once and written once per pixel
// reset needs no clearing pass: the first padded row overwrites every store entry it reads
// input stall comes from registers only: a four-entry queue reserves a slot per pixel in flight
module mask_outer_contour #(
  parameter int unsigned MAX_WIDTH = moc_pkg::DEF_MAX_WIDTH,
  localparam int unsigned ColW = $clog2(MAX_WIDTH + 2)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [moc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           pixel_visible_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           contour_o,
  output logic [ColW-1:0]                out_column_o,
  output logic [moc_pkg::ROW_W-1:0]      out_row_o,
  output logic                           frame_last_o
);

  import moc_pkg::*;

  line_status_t    line_status;
  emit_status_t    emit_status;
  logic [ColW-1:0] push_col;
  rec_t            push_rec;

  // line stage: counters, border forcing, row store read-modify-write,
  // with the right neighbor read one pixel ahead of its use
  moc_line #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .pixel_visible_i (pixel_visible_i),
    .in_stall_o      (in_stall_o),
    .emit_status_i   (emit_status),
    .status_o        (line_status),
    .push_col_o      (push_col),
    .push_rec_o      (push_rec)
  );

  // finished pixels queue up and leave one result per cycle while out_stall_i is low
  moc_emit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .line_status_i (line_status),
    .push_col_i    (push_col),
    .push_rec_i    (push_rec),
    .status_o      (emit_status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .contour_o     (contour_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .frame_last_o  (frame_last_o)
  );

  logic [QCW:0] in_flight;
  assign in_flight = (QCW+1)'(emit_status.count) + (QCW+1)'(line_status.s1_valid);

  // an accepted pixel reaches the store stage on the next cycle
  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> line_status.s1_valid)
    else $error("accepted pixel did not reach store stage");

  // the slot reservation keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_status.push |-> emit_status.count < QCW'(QUEUE_DEPTH))
    else $error("push into full queue");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= (QCW+1)'(QUEUE_DEPTH))
    else $error("more pixels in flight than queue slots");

  // the frame ends on the bottom right corner, never on row or column zero
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> out_row_o != '0 && out_column_o != '0)
    else $error("frame end flagged off the last corner");

endmodule
